>>> design/otp_pkg.sv
`default_nettype none
package otp_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int XY_W            = 34;
    localparam int Z_W             = 32;
    localparam logic signed [XY_W-1:0] CORDIC_ONE_K = 34'sd652032874;

    // Configuration register indexes
    localparam logic [2:0] REG_BOW       = 3'd0;
    localparam logic [2:0] REG_STERN     = 3'd1;
    localparam logic [2:0] REG_PORT      = 3'd2;
    localparam logic [2:0] REG_STARBOARD = 3'd3;
    localparam logic [2:0] REG_STEP_TIME = 3'd4;
    localparam logic [2:0] REG_NUM_SAMP  = 3'd5;

    // Members run from the highest bits down, so pos_x sits in the lowest bits.
    typedef struct packed {
        logic signed [15:0] sway;
        logic signed [15:0] surge;
        logic [15:0]        heading;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } otp_item_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [1:0]             quad;
    } otp_rot_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [16:0] vx;
        logic signed [16:0] vy;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic [15:0]        heading;
    } otp_traj_t;

    // Arctangent of 2^-i, 2^32 per turn.
    function automatic logic signed [Z_W-1:0] atan_val(input int i);
        logic signed [Z_W-1:0] r;
        case (i)
            0:       r = 32'sd536870912;
            1:       r = 32'sd316933406;
            2:       r = 32'sd167458907;
            3:       r = 32'sd85005780;
            4:       r = 32'sd42667331;
            5:       r = 32'sd21354465;
            6:       r = 32'sd10679838;
            7:       r = 32'sd5340245;
            8:       r = 32'sd2670163;
            9:       r = 32'sd1335087;
            10:      r = 32'sd667544;
            11:      r = 32'sd333772;
            12:      r = 32'sd166886;
            13:      r = 32'sd83443;
            14:      r = 32'sd41722;
            15:      r = 32'sd20861;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] r;
        if (v > 41'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -41'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [40:0] v);
        logic signed [16:0] r;
        if (v > 41'sd65535)
            r = 17'sh0FFFF;
        else if (v < -41'sd65536)
            r = 17'sh10000;
        else
            r = v[16:0];
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/otp_cordic_stage.sv
`default_nettype none
module otp_cordic_stage
    import otp_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      en,
    input  wire logic      in_valid,
    input  wire otp_item_t in_item,
    input  wire otp_rot_t  in_rot,
    output logic           out_valid,
    output otp_item_t      out_item,
    output otp_rot_t       out_rot
);

    logic      valid_reg;
    otp_item_t item_reg;
    otp_rot_t  rot_reg;
    otp_rot_t  rot_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [Z_W-1:0]  ang;

    // One rotation step; arithmetic shifts give floor division.
    always_comb
    begin
        dx = in_rot.y >>> STEP;
        dy = in_rot.x >>> STEP;
        ang = atan_val(STEP);
        rot_next = in_rot;
        if (in_rot.z >= 0)
        begin
            rot_next.x = in_rot.x - dx;
            rot_next.y = in_rot.y + dy;
            rot_next.z = in_rot.z - ang;
        end
        else
        begin
            rot_next.x = in_rot.x + dx;
            rot_next.y = in_rot.y - dy;
            rot_next.z = in_rot.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= in_item;
            rot_reg  <= rot_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_rot   = rot_reg;

endmodule
`default_nettype wire

>>> design/otp_rotate.sv
`default_nettype none
module otp_rotate
    import otp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire otp_item_t   in_item,
    input  wire otp_rot_t    in_rot,
    input  wire logic [17:0] bow_length,
    input  wire logic [17:0] stern_length,
    input  wire logic [17:0] port_width,
    input  wire logic [17:0] starboard_width,
    input  wire logic [15:0] step_time,
    output logic             out_valid,
    output otp_traj_t        out_traj
);

    // Stage 1: quadrant mapping and hull offsets.
    logic                   v1_reg;
    otp_item_t              item1_reg;
    logic signed [XY_W-1:0] c1_reg, s1_reg;
    logic signed [18:0]     ox1_reg, oy1_reg;
    logic signed [XY_W-1:0] c_next, s_next;

    // Stage 2: products.
    logic               v2_reg;
    otp_item_t          item2_reg;
    logic signed [52:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic signed [49:0] p_uc_reg, p_vs_reg, p_us_reg, p_vc_reg;

    // Stage 3: rounded sums and saturation.
    logic               v3_reg;
    logic [15:0]        hd3_reg;
    logic signed [31:0] cx3_reg, cy3_reg;
    logic signed [16:0] vx3_reg, vy3_reg;
    logic signed [53:0] sum_x, sum_y;
    logic signed [50:0] sum_u, sum_v;
    logic signed [23:0] off_x, off_y;
    logic signed [20:0] vel_x, vel_y;

    // Stage 4: velocity times step time.
    logic      v4_reg;
    otp_traj_t traj4_reg;
    logic signed [16:0] step_s;

    always_comb
    begin
        unique case (in_rot.quad)
            2'd0:
            begin
                c_next = in_rot.x;
                s_next = in_rot.y;
            end
            2'd1:
            begin
                c_next = -in_rot.y;
                s_next = in_rot.x;
            end
            2'd2:
            begin
                c_next = -in_rot.x;
                s_next = -in_rot.y;
            end
            default:
            begin
                c_next = in_rot.y;
                s_next = -in_rot.x;
            end
        endcase
    end

    always_comb
    begin
        sum_x = 54'(p_xc_reg) - 54'(p_ys_reg) + 54'sd536870912;
        sum_y = 54'(p_xs_reg) + 54'(p_yc_reg) + 54'sd536870912;
        sum_u = 51'(p_uc_reg) - 51'(p_vs_reg) + 51'sd536870912;
        sum_v = 51'(p_us_reg) + 51'(p_vc_reg) + 51'sd536870912;
        off_x = 24'(sum_x >>> 30);
        off_y = 24'(sum_y >>> 30);
        vel_x = 21'(sum_u >>> 30);
        vel_y = 21'(sum_v >>> 30);
        step_s = $signed({1'b0, step_time});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item1_reg <= in_item;
            c1_reg    <= c_next;
            s1_reg    <= s_next;
            ox1_reg   <= $signed({1'b0, bow_length}) - $signed({1'b0, stern_length});
            oy1_reg   <= $signed({1'b0, starboard_width}) - $signed({1'b0, port_width});

            item2_reg <= item1_reg;
            p_xc_reg  <= ox1_reg * c1_reg;
            p_ys_reg  <= oy1_reg * s1_reg;
            p_xs_reg  <= ox1_reg * s1_reg;
            p_yc_reg  <= oy1_reg * c1_reg;
            p_uc_reg  <= item1_reg.surge * c1_reg;
            p_vs_reg  <= item1_reg.sway * s1_reg;
            p_us_reg  <= item1_reg.surge * s1_reg;
            p_vc_reg  <= item1_reg.sway * c1_reg;

            hd3_reg <= item2_reg.heading;
            cx3_reg <= sat32(41'(item2_reg.pos_x) + 41'(off_x));
            cy3_reg <= sat32(41'(item2_reg.pos_y) + 41'(off_y));
            vx3_reg <= sat17(41'(vel_x));
            vy3_reg <= sat17(41'(vel_y));

            traj4_reg.cx      <= cx3_reg;
            traj4_reg.cy      <= cy3_reg;
            traj4_reg.vx      <= vx3_reg;
            traj4_reg.vy      <= vy3_reg;
            traj4_reg.dx      <= step_s * vx3_reg;
            traj4_reg.dy      <= step_s * vy3_reg;
            traj4_reg.heading <= hd3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_traj  = traj4_reg;

endmodule
`default_nettype wire

>>> design/otp_expand.sv
`default_nettype none
module otp_expand
    import otp_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire otp_traj_t   in_traj,
    input  wire logic [6:0]  num_samples,
    output logic             load,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [119:0]     m_tdata,
    output logic             m_tlast
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);

    logic               busy_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   last_reg;
    logic [IDX_W-1:0]   last_next;
    logic signed [39:0] acc_x_reg, acc_y_reg;
    otp_traj_t          traj_reg;

    logic               out_valid_reg;
    logic [5:0]         o_idx_reg;
    logic signed [31:0] o_px_reg, o_py_reg;
    logic signed [16:0] o_vx_reg, o_vy_reg;
    logic [15:0]        o_hd_reg;
    logic               o_last_reg;

    logic can_emit, emit, fin;
    logic signed [31:0] step_x, step_y;

    always_comb
    begin
        if (num_samples == 7'd0)
            last_next = '0;
        else if (num_samples > 7'(MAX_SAMPLES))
            last_next = IDX_W'(MAX_SAMPLES - 1);
        else
            last_next = IDX_W'(num_samples - 7'd1);
        can_emit = !out_valid_reg || m_tready;
        emit     = busy_reg && can_emit;
        fin      = emit && (idx_reg == last_reg);
        load     = in_valid && (!busy_reg || fin);
        step_x   = 32'((acc_x_reg + 40'sd128) >>> 8);
        step_y   = 32'((acc_y_reg + 40'sd128) >>> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_emit)
                out_valid_reg <= busy_reg;
            if (load)
                busy_reg <= 1'b1;
            else if (fin)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            o_idx_reg  <= 6'(idx_reg);
            o_px_reg   <= sat32(41'(traj_reg.cx) + 41'(step_x));
            o_py_reg   <= sat32(41'(traj_reg.cy) + 41'(step_y));
            o_vx_reg   <= traj_reg.vx;
            o_vy_reg   <= traj_reg.vy;
            o_hd_reg   <= traj_reg.heading;
            o_last_reg <= (idx_reg == last_reg);
        end
        if (load)
        begin
            traj_reg  <= in_traj;
            idx_reg   <= '0;
            last_reg  <= last_next;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (emit)
        begin
            idx_reg   <= idx_reg + 1'b1;
            acc_x_reg <= acc_x_reg + 40'(traj_reg.dx);
            acc_y_reg <= acc_y_reg + 40'(traj_reg.dy);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {o_hd_reg, o_vy_reg, o_vx_reg, o_py_reg, o_px_reg, o_idx_reg};

endmodule
`default_nettype wire

>>> design/obstacle_trajectory_predictor.sv
// Path from an accepted request to its first trajectory point on m_tdata: input register, CORDIC
// stages, rotation stages, point generator output register. Throughput: one point per cycle while
// m_tready allows; a report yields num_samples points (1 to MAX_SAMPLES), and the front pipeline
// takes a new report every cycle unless held by the point generator, which sets the sustained rate.
// Reset (rst_n, asynchronous, active low) clears all valid flags and loads the
// configuration defaults: offsets 0, step_time 128, num_samples 64.
`default_nettype none
module obstacle_trajectory_predictor
    import otp_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [17:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], surge_speed[95:80], sway_speed[111:96]
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // sample_index[5:0], pred_x[37:6], pred_y[69:38], vel_x[86:70], vel_y[103:87],
    // heading_out[119:104]
    output logic [119:0]      m_tdata,
    output logic              m_tlast
);

    // Configuration registers.
    logic [17:0] bow_reg, stern_reg, port_reg, stbd_reg;
    logic [15:0] step_reg;
    logic [6:0]  nsamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bow_reg   <= '0;
            stern_reg <= '0;
            port_reg  <= '0;
            stbd_reg  <= '0;
            step_reg  <= 16'd128;
            nsamp_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOW:       bow_reg   <= cfg_data;
                REG_STERN:     stern_reg <= cfg_data;
                REG_PORT:      port_reg  <= cfg_data;
                REG_STARBOARD: stbd_reg  <= cfg_data;
                REG_STEP_TIME: step_reg  <= cfg_data[15:0];
                REG_NUM_SAMP:  nsamp_reg <= cfg_data[6:0];
                default:       ;
            endcase
        end
    end

    // The whole front pipeline advances together; it holds only when its
    // final stage has a finished report that the point generator cannot yet take.
    logic      en;
    logic      rot_valid;
    otp_traj_t rot_traj;
    logic      exp_load;

    assign en       = !rot_valid || exp_load;
    assign s_tready = en;

    // Input register: the request is captured and the CORDIC start vector formed.
    logic      s0_valid_reg;
    otp_item_t s0_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            s0_item_reg <= s_tdata;
    end

    // CORDIC: one iteration per stage. The low 14 heading bits give the angle
    // within the quadrant, scaled to 2^32 per turn.
    logic      cv [CORDIC_STEPS+1];
    otp_item_t ci [CORDIC_STEPS+1];
    otp_rot_t  cr [CORDIC_STEPS+1];

    always_comb
    begin
        cv[0]      = s0_valid_reg;
        ci[0]      = s0_item_reg;
        cr[0].x    = CORDIC_ONE_K;
        cr[0].y    = '0;
        cr[0].z    = $signed({2'b00, s0_item_reg.heading[13:0], 16'h0000});
        cr[0].quad = s0_item_reg.heading[15:14];
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        otp_cordic_stage #(
            .STEP(g)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (cv[g]),
            .in_item  (ci[g]),
            .in_rot   (cr[g]),
            .out_valid(cv[g+1]),
            .out_item (ci[g+1]),
            .out_rot  (cr[g+1])
        );
    end

    // Rotation of the hull offset and the body velocity into the fixed frame.
    otp_rotate u_rotate (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (cv[CORDIC_STEPS]),
        .in_item        (ci[CORDIC_STEPS]),
        .in_rot         (cr[CORDIC_STEPS]),
        .bow_length     (bow_reg),
        .stern_length   (stern_reg),
        .port_width     (port_reg),
        .starboard_width(stbd_reg),
        .step_time      (step_reg),
        .out_valid      (rot_valid),
        .out_traj       (rot_traj)
    );

    // Point generator: walks the trajectory by accumulating step_time * velocity.
    otp_expand #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rot_valid),
        .in_traj    (rot_traj),
        .num_samples(nsamp_reg),
        .load       (exp_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Expected index of the final point under the current configuration.
    logic [6:0] exp_last;
    assign exp_last = (nsamp_reg == 7'd0) ? 7'd0 :
                      (nsamp_reg > 7'(MAX_SAMPLES)) ? 7'(MAX_SAMPLES - 1) :
                      nsamp_reg - 7'd1;

    a_last_index : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> ({1'b0, m_tdata[5:0]} == exp_last))
        else $error("final point carries the wrong sample index");

    a_run_continues : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("trajectory run broken before its final point");

    a_index_steps : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1))
        else $error("sample index did not advance by one");

endmodule
`default_nettype wire
